@@ rtl/core/rational_arith_unit_assert.svh @@
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define RAU_ASSERT(lbl, clk, rstn, prop, msg)
`define RAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/core/rau_pkg.sv @@
`timescale 1ns / 1ps
package rau_pkg;
    localparam int OPERAND_BITS_DEF = 16;
    localparam int IN_W   = 16;
    localparam int W_NUM  = 33;
    localparam int W_DEN  = 31;
    localparam int W_FRAC = 31;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_ABS, S_GSH, S_GLP,
        S_D1S, S_D1W, S_D2S, S_D2W, S_D3S, S_D3W, S_FIN
    } t_state;
endpackage

@@ rtl/core/rau_div.sv @@
`timescale 1ns / 1ps
module rau_div #(
    parameter int WIDTH = 2 * rau_pkg::OPERAND_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot,
    output logic [WIDTH-1:0] o_rem
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_quo, r_rem, r_dv;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [WIDTH:0]   shifted;
    logic             ge;

    assign shifted = {r_rem, r_quo[WIDTH-1]};
    assign ge      = shifted >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dv   <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? WIDTH'(shifted - {1'b0, r_dv}) : WIDTH'(shifted);
                r_quo <= {r_quo[WIDTH-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule

@@ rtl/core/rational_arith_unit.sv @@
`timescale 1ns / 1ps
// One item at a time: start is taken while busy is low, and the result appears
// on o_valid for a single cycle, so the receiver must take it then. An item
// forms three products on the shared multiplier, takes two steps to combine
// and fold the sign, runs a binary gcd of one compare-subtract or shift per
// cycle, then makes three passes of the bit-serial divider, and last forms the
// outputs. When the result denominator is zero it skips the gcd and the
// divider and goes straight to forming the outputs. Busy stays high the
// whole time.
`include "rational_arith_unit_assert.svh"
module rational_arith_unit #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_cmd,
    input  logic [rau_pkg::IN_W-1:0]          i_a_num,
    input  logic [rau_pkg::IN_W-1:0]          i_a_den,
    input  logic [rau_pkg::IN_W-1:0]          i_b_num,
    input  logic [rau_pkg::IN_W-1:0]          i_b_den,
    output logic                              o_valid,
    output logic                              o_status,
    output logic signed [rau_pkg::W_NUM-1:0]  o_raw_num,
    output logic [rau_pkg::W_DEN-1:0]         o_raw_den,
    output logic signed [rau_pkg::W_NUM-1:0]  o_red_num,
    output logic [rau_pkg::W_DEN-1:0]         o_red_den,
    output logic signed [rau_pkg::W_NUM-1:0]  o_whole_part,
    output logic signed [rau_pkg::W_FRAC-1:0] o_frac_num
);
    import rau_pkg::*;

    localparam int OB = OPERAND_BITS;
    localparam int MW = 2 * OB;
    localparam int SW = MW + 1;
    localparam int KW = $clog2(MW + 1);

    t_state r_state, n_state;

    logic [1:0]             r_cmd;
    logic signed [OB-1:0]   r_an, r_ad, r_bn, r_bd;
    logic signed [MW-1:0]   r_p0, r_p1, r_p2;
    logic signed [SW-1:0]   r_num;
    logic [MW-1:0]          r_den, r_mag, r_x, r_y, r_g, r_rmag, r_rden, r_q, r_r;
    logic [KW-1:0]          r_k;
    logic                   r_neg, r_stat, r_valid;

    logic signed [OB-1:0]   m_a, m_b;
    logic signed [MW-1:0]   m_p;
    logic signed [SW-1:0]   sum;
    logic [MW:0]            diff;
    logic                   div_start, div_done;
    logic [MW-1:0]          div_a, div_b, div_q, div_r;
    logic signed [SW-1:0]   rn, wh, fr;

    // shared multiplier
    always_comb begin
        m_a = r_ad;
        m_b = r_bd;
        case (r_state)
            S_MUL0: begin
                m_a = r_an;
                m_b = (r_cmd == CMD_MUL) ? r_bn : r_bd;
            end
            S_MUL1: begin
                m_a = r_ad;
                m_b = r_bn;
            end
            S_MUL2: begin
                m_a = r_ad;
                m_b = (r_cmd == CMD_DIV) ? r_bn : r_bd;
            end
            default: begin
                m_a = r_ad;
                m_b = r_bd;
            end
        endcase
    end
    assign m_p = m_a * m_b;

    always_comb begin
        case (r_cmd)
            CMD_ADD: sum = SW'(r_p0) + SW'(r_p1);
            CMD_SUB: sum = SW'(r_p0) - SW'(r_p1);
            default: sum = SW'(r_p0);
        endcase
    end

    assign diff = {1'b0, r_x} - {1'b0, r_y};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_COMB;
            S_COMB: n_state = S_ABS;
            S_ABS:  n_state = (r_den == '0) ? S_FIN : S_GSH;
            S_GSH:  if (r_x[0] || r_y[0]) n_state = S_GLP;
            S_GLP:  if (r_x == '0 || r_y == '0) n_state = S_D1S;
            S_D1S:  n_state = S_D1W;
            S_D1W:  if (div_done) n_state = S_D2S;
            S_D2S:  n_state = S_D2W;
            S_D2W:  if (div_done) n_state = S_D3S;
            S_D3S:  n_state = S_D3W;
            S_D3W:  if (div_done) n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        busy      = (r_state != S_IDLE);
        div_start = 1'b0;
        div_a     = r_rmag;
        div_b     = r_rden;
        case (r_state)
            S_D1S: begin
                div_start = 1'b1;
                div_a     = r_mag;
                div_b     = r_g;
            end
            S_D2S: begin
                div_start = 1'b1;
                div_a     = r_den;
                div_b     = r_g;
            end
            S_D3S: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    rau_div #(.WIDTH(MW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    assign rn = r_neg ? -signed'({1'b0, r_rmag}) : signed'({1'b0, r_rmag});
    assign wh = r_neg ? -signed'({1'b0, r_q}) : signed'({1'b0, r_q});
    assign fr = (r_neg && r_q == '0) ? -signed'({1'b0, r_r}) : signed'({1'b0, r_r});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_FIN);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd <= i_cmd;
                r_an  <= signed'(OB'(i_a_num));
                r_ad  <= signed'(OB'(i_a_den));
                r_bn  <= signed'(OB'(i_b_num));
                r_bd  <= signed'(OB'(i_b_den));
            end
            S_MUL0: r_p0 <= m_p;
            S_MUL1: r_p1 <= m_p;
            S_MUL2: r_p2 <= m_p;
            S_COMB: begin
                r_num <= r_p2[MW-1] ? -sum : sum;
                r_den <= r_p2[MW-1] ? MW'(-r_p2) : MW'(r_p2);
            end
            S_ABS: begin
                r_neg  <= r_num[SW-1];
                r_mag  <= r_num[SW-1] ? MW'(-r_num) : MW'(r_num);
                r_x    <= r_num[SW-1] ? MW'(-r_num) : MW'(r_num);
                r_y    <= r_den;
                r_k    <= '0;
                r_stat <= (r_den == '0);
            end
            S_GSH: begin
                if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + KW'(1);
                end
            end
            S_GLP: begin
                if (r_x == '0) begin
                    r_g <= MW'(r_y << r_k);
                end else if (r_y == '0) begin
                    r_g <= MW'(r_x << r_k);
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (!diff[MW]) begin
                    r_x <= diff[MW-1:0];
                end else begin
                    r_y <= MW'(-diff);
                end
            end
            S_D1W: if (div_done) r_rmag <= div_q;
            S_D2W: if (div_done) r_rden <= div_q;
            S_D3W: begin
                if (div_done) begin
                    r_q <= div_q;
                    r_r <= div_r;
                end
            end
            S_FIN: begin
                o_status  <= r_stat;
                o_raw_num <= W_NUM'(r_num);
                o_raw_den <= W_DEN'(r_den);
                if (r_stat) begin
                    o_red_num    <= '0;
                    o_red_den    <= '0;
                    o_whole_part <= '0;
                    o_frac_num   <= '0;
                end else begin
                    o_red_num    <= W_NUM'(rn);
                    o_red_den    <= W_DEN'(r_rden);
                    o_whole_part <= W_NUM'(wh);
                    o_frac_num   <= W_FRAC'(fr);
                end
            end
            default: begin
                r_cmd <= r_cmd;
            end
        endcase
    end

    assign o_valid = r_valid;

    `RAU_ASSERT(a_valid_idle, i_clk, i_rst_n, o_valid |-> (r_state == S_IDLE), "result outside idle")
    `RAU_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "item not taken")
    `RAU_ASSERT(a_div_done, i_clk, i_rst_n, div_done |-> (r_state == S_D1W || r_state == S_D2W || r_state == S_D3W), "divider done out of step")
endmodule

@@ bench/rational_arith_unit_test.sv @@
`timescale 1ns / 1ps
module rational_arith_unit_test;
    import rau_pkg::*;

    typedef struct packed {
        logic                     status;
        logic signed [W_NUM-1:0]  raw_num;
        logic [W_DEN-1:0]         raw_den;
        logic signed [W_NUM-1:0]  red_num;
        logic [W_DEN-1:0]         red_den;
        logic signed [W_NUM-1:0]  whole_part;
        logic signed [W_FRAC-1:0] frac_num;
    } t_fraction_result;

    typedef struct {
        logic [1:0]       cmd;
        logic [IN_W-1:0]  a_num;
        logic [IN_W-1:0]  a_den;
        logic [IN_W-1:0]  b_num;
        logic [IN_W-1:0]  b_den;
        bit               has_fixed;
        t_fraction_result fixed;
    } t_stimulus_row;

    localparam int STALL_LIMIT = 4000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_cmd;
    logic [IN_W-1:0]          i_a_num;
    logic [IN_W-1:0]          i_a_den;
    logic [IN_W-1:0]          i_b_num;
    logic [IN_W-1:0]          i_b_den;
    logic                     o_valid;
    logic                     o_status;
    logic signed [W_NUM-1:0]  o_raw_num;
    logic [W_DEN-1:0]         o_raw_den;
    logic signed [W_NUM-1:0]  o_red_num;
    logic [W_DEN-1:0]         o_red_den;
    logic signed [W_NUM-1:0]  o_whole_part;
    logic signed [W_FRAC-1:0] o_frac_num;

    t_fraction_result pending_fractions[$];
    t_stimulus_row    directed_rows[$];
    int               mismatch_count;
    int               quiet_cycles;
    int               sender_gap_pct;

    rational_arith_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den), .o_valid(o_valid),
        .o_status(o_status), .o_raw_num(o_raw_num), .o_raw_den(o_raw_den),
        .o_red_num(o_red_num), .o_red_den(o_red_den),
        .o_whole_part(o_whole_part), .o_frac_num(o_frac_num)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic t_fraction_result reduce_fraction(logic [1:0] cmd,
            logic [IN_W-1:0] an_v, logic [IN_W-1:0] ad_v,
            logic [IN_W-1:0] bn_v, logic [IN_W-1:0] bd_v);
        longint an, ad, bn, bd, num, den, rn, rd, whole, frac;
        longint unsigned mag, g, q;
        t_fraction_result res;
        an = longint'($signed(an_v));
        ad = longint'($signed(ad_v));
        bn = longint'($signed(bn_v));
        bd = longint'($signed(bd_v));
        rn = 0;
        rd = 0;
        whole = 0;
        frac = 0;
        case (cmd)
            CMD_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
            CMD_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
            CMD_MUL: begin num = an * bn; den = ad * bd; end
            default: begin num = an * bd; den = ad * bn; end
        endcase
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        res.status = (den == 0);
        if (den != 0) begin
            mag = (num < 0) ? -num : num;
            g = gcd_of(mag, den);
            mag = mag / g;
            rd = den / g;
            q = mag / rd;
            frac = mag % rd;
            rn = (num < 0) ? -longint'(mag) : longint'(mag);
            whole = (num < 0) ? -longint'(q) : longint'(q);
            if (whole == 0 && num < 0) frac = -frac;
        end
        res.raw_num = num[W_NUM-1:0];
        res.raw_den = den[W_DEN-1:0];
        res.red_num = rn[W_NUM-1:0];
        res.red_den = rd[W_DEN-1:0];
        res.whole_part = whole[W_NUM-1:0];
        res.frac_num = frac[W_FRAC-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        mismatch_count++;
    endtask

    task automatic add_row(logic [1:0] c, int an, int ad, int bn, int bd,
            bit fixed_on = 0, t_fraction_result fx = '0);
        t_stimulus_row row;
        row.cmd = c;
        row.a_num = an[IN_W-1:0];
        row.a_den = ad[IN_W-1:0];
        row.b_num = bn[IN_W-1:0];
        row.b_den = bd[IN_W-1:0];
        row.has_fixed = fixed_on;
        row.fixed = fx;
        directed_rows.push_back(row);
    endtask

    task automatic send_fraction(logic [1:0] c, logic [IN_W-1:0] an,
            logic [IN_W-1:0] ad, logic [IN_W-1:0] bn, logic [IN_W-1:0] bd,
            bit fixed_on, t_fraction_result fx);
        while ($urandom_range(99) < sender_gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd <= c;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_fractions.push_back(fixed_on ? fx : reduce_fraction(c, an, ad, bn, bd));
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pick_operand();
        case ($urandom_range(5))
            0: return IN_W'($urandom_range(9));
            1: return -IN_W'($urandom_range(9));
            2: return IN_W'($urandom_range(255)) - 16'd128;
            3: return {1'b1, 15'($urandom)};
            4: return {1'b0, 15'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_fraction_result want;
        if (i_rst_n && o_valid) begin
            if (pending_fractions.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = pending_fractions.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_raw_num !== want.raw_num) report_mismatch("raw_num", o_raw_num, want.raw_num);
                if (o_raw_den !== want.raw_den) report_mismatch("raw_den", o_raw_den, want.raw_den);
                if (o_red_num !== want.red_num) report_mismatch("red_num", o_red_num, want.red_num);
                if (o_red_den !== want.red_den) report_mismatch("red_den", o_red_den, want.red_den);
                if (o_whole_part !== want.whole_part)
                    report_mismatch("whole_part", o_whole_part, want.whole_part);
                if (o_frac_num !== want.frac_num)
                    report_mismatch("frac_num", o_frac_num, want.frac_num);
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_valid || (start && !busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_fraction_result fx;
        mismatch_count = 0;
        quiet_cycles = 0;
        sender_gap_pct = 0;
        start = 1'b0;
        i_cmd = CMD_ADD;
        i_a_num = '0;
        i_a_den = '0;
        i_b_num = '0;
        i_b_den = '0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero denominators flag status
        fx = '0;
        fx.status = 1'b1;
        fx.raw_num = 33'd1;
        add_row(CMD_ADD, 1, 0, 1, 1, 1, fx);
        fx.raw_num = '0;
        add_row(CMD_MUL, 0, 5, 0, 0, 1, fx);
        add_row(CMD_DIV, 0, 1, 0, 1, 1, fx);
        // zero numerator reduces to 0/1
        fx = '0;
        fx.raw_den = 31'd12;
        fx.red_den = 31'd1;
        add_row(CMD_MUL, 0, 3, 7, 4, 1, fx);
        fx = '0;
        fx.raw_num = 33'd1;
        fx.raw_den = 31'd1;
        fx.red_num = 33'd1;
        fx.red_den = 31'd1;
        fx.whole_part = 33'd1;
        add_row(CMD_MUL, 1, 1, 1, 1, 1, fx);
        add_row(CMD_ADD, 1, 2, 1, 3);
        add_row(CMD_SUB, 1, 2, 1, 3);
        add_row(CMD_SUB, 1, 3, 1, 2);
        add_row(CMD_MUL, -7, 3, 5, -2);
        add_row(CMD_DIV, 3, -4, -9, 8);
        add_row(CMD_ADD, -32768, -32768, -32768, -32768);
        add_row(CMD_SUB, -32768, 1, 32767, 1);
        add_row(CMD_MUL, -32768, 1, -32768, 1);
        add_row(CMD_MUL, 32767, -32768, 32767, -32768);
        add_row(CMD_DIV, 32767, 1, -32768, 1);
        add_row(CMD_DIV, -32768, 32767, 32767, -32768);
        add_row(CMD_ADD, 32767, 32767, 32767, 32767);
        add_row(CMD_SUB, -1, 7, 0, 1);
        add_row(CMD_DIV, 22, 7, 1, 1);
        add_row(CMD_SUB, 0, -5, 3, 5);
        @(negedge i_clk);
        foreach (directed_rows[k])
            send_fraction(directed_rows[k].cmd, directed_rows[k].a_num,
                directed_rows[k].a_den, directed_rows[k].b_num,
                directed_rows[k].b_den, directed_rows[k].has_fixed,
                directed_rows[k].fixed);
        start <= 1'b0;

        // sender pauses until the queue drains
        while (pending_fractions.size() != 0) @(negedge i_clk);

        for (int n = 0; n < 450; n++) begin
            sender_gap_pct = (n < 150) ? 7 : (n < 300) ? 53 : 0;
            send_fraction(2'($urandom), pick_operand(), pick_operand(),
                pick_operand(), pick_operand(), 0, '0);
        end
        start <= 1'b0;

        while (pending_fractions.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
